// ===== hdl/mcop_pkg.sv =====
`default_nettype none
package mcop_pkg;
    localparam logic [31:0] LOG2E_Q30 = 32'd1549082005;
    localparam int NUM_COEF = 9;

    function automatic logic [31:0] pow2_coef(input logic [3:0] idx);
        logic [31:0] c;
        case (idx)
            4'd0: c = 32'd2977044472;
            4'd1: c = 32'd1031764991;
            4'd2: c = 32'd238388332;
            4'd3: c = 32'd41309550;
            4'd4: c = 32'd5726720;
            4'd5: c = 32'd661577;
            4'd6: c = 32'd65510;
            4'd7: c = 32'd5676;
            4'd8: c = 32'd437;
            default: c = 32'd0;
        endcase
        return c;
    endfunction

    localparam logic [2:0] REG_SPOT      = 3'd0;
    localparam logic [2:0] REG_STRIKE    = 3'd1;
    localparam logic [2:0] REG_DRIFT     = 3'd2;
    localparam logic [2:0] REG_DIFFUSION = 3'd3;
    localparam logic [2:0] REG_STEPS     = 3'd4;
    localparam logic [2:0] REG_PATHS     = 3'd5;
    localparam logic [2:0] REG_SCALE     = 3'd6;
    localparam logic [2:0] REG_PUT       = 3'd7;

    typedef enum logic [6:0] {
        t_ST_IDLE  = 7'b0000001,
        t_ST_LOG2  = 7'b0000010,
        t_ST_HORN  = 7'b0000100,
        t_ST_PRICE = 7'b0001000,
        t_ST_SHIFT = 7'b0010000,
        t_ST_SCALE = 7'b0100000,
        t_ST_OUT   = 7'b1000000
    } t_state;
endpackage
`default_nettype wire

// ===== hdl/mcop_mul.sv =====
`default_nettype none
// Shared 33x33 signed multiplier with registered product.
module mcop_mul (
    input  wire         i_clk,
    input  wire  [32:0] i_a,
    input  wire  [32:0] i_b,
    output logic [65:0] o_p
);
    always_ff @(posedge i_clk) begin
        o_p <= 66'($signed(i_a) * $signed(i_b));
    end
endmodule
`default_nettype wire

// ===== hdl/monte_carlo_option_pricer.sv =====
`default_nettype none
// Monte Carlo pricer for European options (geometric Brownian motion).
// Input stream: one standard normal sample (Q3.12) per transaction on s_axis.
// Configuration: write i_cfg_we with i_cfg_addr (register index) and i_cfg_data
// while the block is idle; registers keep their values across results.
// A sample inside a path is taken without a stall, and s_axis_tready stays high.
// A sample that ends a path keeps the block busy while exp is computed (via
// a Horner sequence on one shared 33x33 multiplier) and the end price formed;
// the sample ending the last path also keeps it busy for the four 32-bit
// partial products of sum times scale before its result is registered.
// Output stream: one transaction on m_axis per configured path count, carrying
// the price and a saturation flag. The result sits in an output register; new
// samples are taken while it waits, but the block holds before it would
// produce another result over an untaken one.
// Reset (synchronous, active low) restores the default configuration and
// clears all path, sum and count state and the output valid.
module monte_carlo_option_pricer #(
    parameter int STEP_COUNT_WIDTH = 16,
    parameter int PATH_COUNT_WIDTH = 24,
    parameter int SUM_WIDTH        = 56
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_addr,
    input  wire  [47:0] i_cfg_data,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [15:0] s_axis_tdata,   // [15:0] normal_sample
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] option_price
    output logic        m_axis_tuser    // [0] saturated
);
    import mcop_pkg::*;

    localparam int SW = STEP_COUNT_WIDTH;
    localparam int PW = PATH_COUNT_WIDTH;

    logic [31:0] r_spot, r_strike, r_drift;
    logic [30:0] r_diff;
    logic [15:0] r_steps;
    logic [23:0] r_paths;
    logic [47:0] r_scale;
    logic        r_put;

    logic [31:0]        r_log;
    logic [SW-1:0]      r_step;
    logic [PW-1:0]      r_path;
    logic [SUM_WIDTH-1:0] r_sum;
    logic               r_ovf;
    t_state             r_state;
    logic [3:0]         r_cnt;
    logic [31:0]        r_f;       // fraction Q0.30
    logic [9:0]         r_n;       // integer part + 256
    logic [33:0]        r_p;       // Horner accumulator
    logic [63:0]        r_prod;
    logic               r_last;    // path ends the price
    logic               r_wait;    // product pending in multiplier
    logic [SUM_WIDTH+47:0] r_acc;  // scale product accumulator
    logic [31:0]        r_out;
    logic               r_osat;
    logic               r_ovalid;

    logic [32:0] w_a, w_b;
    logic [65:0] w_p;
    logic [SUM_WIDTH+47:0] w_pw;

    mcop_mul u_mul (.i_clk(i_clk), .i_a(w_a), .i_b(w_b), .o_p(w_p));

    assign w_pw = (SUM_WIDTH+48)'(w_p);

    // step limit / path limit (zero acts as one, clipped to counter range)
    logic [SW:0] w_slim;
    logic [PW:0] w_plim;
    always_comb begin
        logic [16:0] s17;
        logic [24:0] p25;
        s17 = (r_steps == 16'd0) ? 17'd1 : {1'b0, r_steps};
        p25 = (r_paths == 24'd0) ? 25'd1 : {1'b0, r_paths};
        if (SW >= 17 || s17 <= 17'(1 << SW)) w_slim = (SW+1)'(s17);
        else w_slim = (SW+1)'(1) << SW;
        if (PW >= 25 || p25 <= 25'(1 << PW)) w_plim = (PW+1)'(p25);
        else w_plim = (PW+1)'(1) << PW;
    end

    // sample-step log update; uses a dedicated 31x16 product
    logic signed [47:0] w_dprod;
    logic signed [35:0] w_dsh;
    logic signed [36:0] w_nl;
    logic [31:0]        w_nlog;
    logic               w_nsat;
    always_comb begin
        w_dprod = $signed({1'b0, r_diff}) * $signed(s_axis_tdata);
        w_dsh   = 36'(w_dprod >>> 12);
        w_nl    = 37'($signed(r_log)) + 37'($signed(r_drift)) + 37'(w_dsh);
        w_nsat  = 1'b0;
        if (w_nl > 37'sd2147483647) begin
            w_nlog = 32'h7FFF_FFFF; w_nsat = 1'b1;
        end else if (w_nl < -37'sd2147483648) begin
            w_nlog = 32'h8000_0000; w_nsat = 1'b1;
        end else begin
            w_nlog = w_nl[31:0];
        end
    end

    assign s_axis_tready = (r_state == t_ST_IDLE);
    wire w_acc = s_axis_tvalid && s_axis_tready;

    // multiplier operand selection
    logic [3:0] w_cidx;
    always_comb begin
        w_a = '0; w_b = '0;
        w_cidx = 4'(r_cnt - 4'd1);
        case (r_state)
            t_ST_LOG2: begin
                w_a = 33'($signed(r_log));
                w_b = {1'b0, LOG2E_Q30};
            end
            t_ST_HORN: begin
                w_a = {1'b0, r_p[31:0]};
                w_b = {1'b0, r_f};
            end
            t_ST_PRICE: begin
                w_a = {1'b0, r_spot};
                w_b = {1'b0, r_p[32:1]};
            end
            t_ST_SCALE: begin
                w_a = {1'b0, r_cnt[1] ? 32'(r_sum >> 32) : r_sum[31:0]};
                w_b = {1'b0, r_cnt[0] ? {16'd0, r_scale[47:32]} : r_scale[31:0]};
            end
            default: ;
        endcase
    end

    // end price from r_prod and r_n, its payoff and the new payoff sum
    logic [31:0] w_price;
    logic        w_psat;
    logic [31:0] w_pay;
    logic [SUM_WIDTH:0] w_nsum;
    always_comb begin
        logic signed [10:0] sh;
        logic [63:0] r;
        sh = 11'sd31 - ($signed({1'b0, r_n}) - 11'sd256);
        w_psat = 1'b0;
        r = '0;
        if (r_prod == 64'd0) w_price = '0;
        else if (sh >= 11'sd64) w_price = '0;
        else if (sh > 11'sd0) begin
            r = r_prod >> sh[5:0];
            if (r[63:32] != '0) begin w_price = '1; w_psat = 1'b1; end
            else w_price = r[31:0];
        end else if (-sh >= 11'sd32 || r_prod > (64'hFFFF_FFFF >> 6'(-sh))) begin
            w_price = '1; w_psat = 1'b1;
        end else begin
            r = r_prod << 6'(-sh);
            w_price = r[31:0];
        end
        if (r_put) w_pay = (r_strike > w_price) ? r_strike - w_price : 32'd0;
        else       w_pay = (w_price > r_strike) ? w_price - r_strike : 32'd0;
        w_nsum = {1'b0, r_sum} + (SUM_WIDTH+1)'(w_pay);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spot <= 32'd6553600; r_strike <= 32'd6553600; r_drift <= '0;
            r_diff <= '0; r_steps <= 16'd252; r_paths <= 24'd1; r_scale <= '0;
            r_put <= 1'b0;
            r_log <= '0; r_step <= '0; r_path <= '0; r_sum <= '0; r_ovf <= 1'b0;
            r_state <= t_ST_IDLE; r_cnt <= '0; r_wait <= 1'b0; r_ovalid <= 1'b0;
            r_last <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_SPOT:      r_spot   <= i_cfg_data[31:0];
                    REG_STRIKE:    r_strike <= i_cfg_data[31:0];
                    REG_DRIFT:     r_drift  <= i_cfg_data[31:0];
                    REG_DIFFUSION: r_diff   <= i_cfg_data[30:0];
                    REG_STEPS:     r_steps  <= i_cfg_data[15:0];
                    REG_PATHS:     r_paths  <= i_cfg_data[23:0];
                    REG_SCALE:     r_scale  <= i_cfg_data;
                    REG_PUT:       r_put    <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (r_ovalid && m_axis_tready && r_state != t_ST_OUT) r_ovalid <= 1'b0;
            case (r_state)
                t_ST_IDLE: begin
                    if (w_acc) begin
                        r_log <= w_nlog;
                        if (w_nsat) r_ovf <= 1'b1;
                        if ((SW+1)'(r_step) + (SW+1)'(1) < w_slim) begin
                            r_step <= r_step + SW'(1);
                        end else begin
                            r_step  <= '0;
                            r_last  <= !((PW+1)'(r_path) + (PW+1)'(1) < w_plim);
                            r_wait  <= 1'b0;
                            r_state <= t_ST_LOG2;
                        end
                    end
                end
                t_ST_LOG2: begin
                    r_wait <= !r_wait;
                    if (r_wait) begin
                        logic [65:0] u;
                        u = w_p + (66'd1 << 62);
                        r_n <= u[63:54];
                        r_f <= {2'b0, u[53:24]};
                        r_p <= 34'(pow2_coef(4'd8));
                        r_cnt <= 4'd8;
                        r_state <= t_ST_HORN;
                    end
                end
                t_ST_HORN: begin
                    r_wait <= !r_wait;
                    if (r_wait) begin
                        if (r_cnt == 4'd0) begin
                            r_p <= 34'((66'd1 << 32) + (w_p >> 30));
                            r_state <= t_ST_PRICE;
                        end else begin
                            r_p <= 34'(pow2_coef(w_cidx)) + 34'(w_p >> 30);
                            r_cnt <= w_cidx;
                        end
                    end
                end
                t_ST_PRICE: begin
                    r_wait <= !r_wait;
                    if (r_wait) begin
                        r_prod  <= w_p[63:0];
                        r_state <= t_ST_SHIFT;
                    end
                end
                t_ST_SHIFT: begin
                    r_log <= '0;
                    if (w_psat || w_nsum[SUM_WIDTH]) r_ovf <= 1'b1;
                    if (w_nsum[SUM_WIDTH]) begin
                        r_sum <= '1;
                    end else begin
                        r_sum <= w_nsum[SUM_WIDTH-1:0];
                    end
                    if (r_last) begin
                        r_cnt <= 4'd0; r_acc <= '0; r_wait <= 1'b0;
                        r_state <= t_ST_SCALE;
                    end else begin
                        r_path <= r_path + PW'(1);
                        r_state <= t_ST_IDLE;
                    end
                end
                t_ST_SCALE: begin
                    // partial products: lo*lo, lo*hi, hi*lo, hi*hi
                    r_wait <= !r_wait;
                    if (r_wait) begin
                        case (r_cnt[1:0])
                            2'd0: r_acc <= w_pw;
                            2'd3: r_acc <= r_acc + (w_pw << 64);
                            default: r_acc <= r_acc + (w_pw << 32);
                        endcase
                        if (r_cnt == 4'd3) r_state <= t_ST_OUT;
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                t_ST_OUT: begin
                    // hold until the output register is free; keep bits 79:48
                    if (!r_ovalid || m_axis_tready) begin
                        if (r_acc[SUM_WIDTH+47:80] != '0) begin
                            r_out <= '1; r_osat <= 1'b1;
                        end else begin
                            r_out <= r_acc[79:48]; r_osat <= r_ovf;
                        end
                        r_ovalid <= 1'b1;
                        r_log <= '0; r_step <= '0; r_path <= '0; r_sum <= '0;
                        r_ovf <= 1'b0;
                        r_state <= t_ST_IDLE;
                    end
                end
                default: r_state <= t_ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_out;
    assign m_axis_tuser  = r_osat;
endmodule
`default_nettype wire

// ===== dv/mcop_checker.sv =====
`timescale 1ns / 100ps
module mcop_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_addr,
    input  wire  [47:0] i_cfg_data,
    input  wire         i_s_tvalid,
    input  wire         i_s_tready,
    input  wire  [15:0] i_s_tdata,
    input  wire         i_m_tvalid,
    input  wire         i_m_tready,
    input  wire  [31:0] i_m_tdata,
    input  wire         i_m_tuser,
    output int          o_errors,
    output int          o_pending,
    output int          o_results
);
    import mcop_pkg::*;

    typedef struct packed {
        logic [31:0] price;
        logic        saturated;
    } price_t;

    localparam longint unsigned SUM_MAX = (64'd1 << 56) - 1;
    localparam longint unsigned MASK32  = 64'hFFFF_FFFF;
    localparam longint unsigned COEF[NUM_COEF] = '{
        64'd2977044472, 64'd1031764991, 64'd238388332, 64'd41309550, 64'd5726720,
        64'd661577, 64'd65510, 64'd5676, 64'd437
    };

    logic [31:0] cfg_spot, cfg_strike, cfg_drift;
    logic [30:0] cfg_diff;
    logic [15:0] cfg_steps;
    logic [23:0] cfg_paths;
    logic [47:0] cfg_scale;
    logic        cfg_put;

    logic [31:0]     log_off;
    longint unsigned step_idx, path_idx, pay_sum;
    bit              sat_seen;
    price_t          price_queue[$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_results = 0;
    end

    function automatic logic [31:0] terminal_price(input logic [31:0] lo,
                                                   input logic [31:0] sp,
                                                   output bit ovf);
        longint x, n, sh;
        longint unsigned u, f, p, m, pr, r;
        ovf = 0;
        x  = longint'($signed(lo));
        u  = longint'(x) * longint'(LOG2E_Q30) + (64'd1 << 62);
        n  = longint'(u >> 54) - 256;
        f  = (u >> 24) & ((64'd1 << 30) - 1);
        p  = COEF[8];
        for (int k = 7; k >= 0; k--)
            p = COEF[k] + ((p * f) >> 30);
        m  = ((64'd1 << 32) + ((p * f) >> 30)) >> 1;
        pr = {32'd0, sp} * m;
        sh = 31 - n;
        if (pr == 0 || sh >= 64)
            return 32'd0;
        if (sh > 0) begin
            r = pr >> sh;
            if (r > MASK32) begin
                ovf = 1;
                return 32'hFFFF_FFFF;
            end
            return r[31:0];
        end
        if (-sh >= 32 || pr > (MASK32 >> (-sh))) begin
            ovf = 1;
            return 32'hFFFF_FFFF;
        end
        r = pr << (-sh);
        return r[31:0];
    endfunction

    task automatic take_sample(input logic [15:0] raw);
        longint          prod, nl;
        longint unsigned lim, pay;
        logic [31:0]     s;
        logic [127:0]    full, r;
        bit              ovf;
        price_t          res;
        prod = longint'($signed({1'b0, cfg_diff})) * longint'($signed(raw));
        nl   = longint'($signed(log_off)) + longint'($signed(cfg_drift)) + (prod >>> 12);
        if (nl > 64'sd2147483647) begin
            nl = 64'sd2147483647;
            sat_seen = 1;
        end
        if (nl < -64'sd2147483648) begin
            nl = -64'sd2147483648;
            sat_seen = 1;
        end
        log_off = nl[31:0];
        lim = (cfg_steps == 0) ? 1 : cfg_steps;
        if (step_idx + 1 < lim) begin
            step_idx++;
            return;
        end
        step_idx = 0;
        s = terminal_price(log_off, cfg_spot, ovf);
        if (ovf)
            sat_seen = 1;
        if (cfg_put)
            pay = (cfg_strike > s) ? cfg_strike - s : 0;
        else
            pay = (s > cfg_strike) ? s - cfg_strike : 0;
        if (pay_sum > SUM_MAX - pay) begin
            pay_sum = SUM_MAX;
            sat_seen = 1;
        end else begin
            pay_sum += pay;
        end
        log_off = 0;
        lim = (cfg_paths == 0) ? 1 : cfg_paths;
        if (path_idx + 1 < lim) begin
            path_idx++;
            return;
        end
        full = {64'd0, pay_sum} * {80'd0, cfg_scale};
        r    = full >> 48;
        res.saturated = sat_seen;
        if (r > 128'hFFFF_FFFF) begin
            res.price = 32'hFFFF_FFFF;
            res.saturated = 1;
        end else begin
            res.price = r[31:0];
        end
        price_queue.insert(price_queue.size(), res);
        path_idx = 0;
        pay_sum  = 0;
        sat_seen = 0;
    endtask

    always @(posedge i_clk) begin
        price_t want;
        if (!i_rst_n) begin
            cfg_spot   = 32'd6553600;
            cfg_strike = 32'd6553600;
            cfg_drift  = 0;
            cfg_diff   = 0;
            cfg_steps  = 16'd252;
            cfg_paths  = 24'd1;
            cfg_scale  = 0;
            cfg_put    = 0;
            log_off    = 0;
            step_idx   = 0;
            path_idx   = 0;
            pay_sum    = 0;
            sat_seen   = 0;
            price_queue.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_SPOT:      cfg_spot   = i_cfg_data[31:0];
                    REG_STRIKE:    cfg_strike = i_cfg_data[31:0];
                    REG_DRIFT:     cfg_drift  = i_cfg_data[31:0];
                    REG_DIFFUSION: cfg_diff   = i_cfg_data[30:0];
                    REG_STEPS:     cfg_steps  = i_cfg_data[15:0];
                    REG_PATHS:     cfg_paths  = i_cfg_data[23:0];
                    REG_SCALE:     cfg_scale  = i_cfg_data[47:0];
                    REG_PUT:       cfg_put    = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                take_sample(i_s_tdata);
            if (i_m_tvalid && i_m_tready) begin
                o_results++;
                if (price_queue.size() == 0) begin
                    $error("unexpected price transaction: option_price %h saturated %b",
                           i_m_tdata, i_m_tuser);
                    o_errors++;
                end else begin
                    want = price_queue.pop_front();
                    if (i_m_tdata !== want.price) begin
                        $error("option_price expected %h actual %h", want.price, i_m_tdata);
                        o_errors++;
                    end
                    if (i_m_tuser !== want.saturated) begin
                        $error("saturated expected %b actual %b", want.saturated, i_m_tuser);
                        o_errors++;
                    end
                end
            end
        end
        o_pending = price_queue.size();
    end
endmodule

// ===== dv/monte_carlo_option_pricer_test.sv =====
`timescale 1ns / 100ps
module monte_carlo_option_pricer_test;
    import mcop_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [2:0]  cfg_addr = 0;
    logic [47:0] cfg_data = 0;
    logic        s_tvalid = 0;
    logic [15:0] s_tdata = 0;
    logic        m_tready = 0;
    wire         s_tready, m_tvalid, m_tuser;
    wire  [31:0] m_tdata;
    int          errors, pending, results;
    int          cycles = 0;
    int          samples_sent = 0;
    int          settings_used = 0;
    bit          hold_req = 0;
    bit          no_idle = 0;

    always begin
        #5 clk = 1;
        #5 clk = 0;
    end

    monte_carlo_option_pricer dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_data(cfg_data),
        .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready), .s_axis_tdata(s_tdata),
        .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready),
        .m_axis_tdata(m_tdata), .m_axis_tuser(m_tuser)
    );

    mcop_checker chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_data(cfg_data),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .i_m_tuser(m_tuser),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d prices outstanding", cycles, pending);
            $display("monte_carlo_option_pricer_test failed");
            $finish;
        end
    end

    // Result side: random wait per transaction, one long hold-off on request.
    initial begin
        int n;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                n = 400;
                hold_req = 0;
            end else begin
                n = no_idle ? 0 : $urandom_range(0, 6);
            end
            if (n > 0) begin
                m_tready = 0;
                repeat (n) @(negedge clk);
            end
            m_tready = 1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
        end
    end

    task automatic write_reg(input logic [2:0] addr, input logic [47:0] data);
        @(negedge clk);
        cfg_we   = 1;
        cfg_addr = addr;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 0;
    endtask

    task automatic program_pricer(input logic [31:0] sp, input logic [31:0] k,
                                  input logic [31:0] dr, input logic [30:0] df,
                                  input logic [15:0] st, input logic [23:0] np,
                                  input logic [47:0] sc, input bit put);
        write_reg(REG_SPOT, {16'd0, sp});
        write_reg(REG_STRIKE, {16'd0, k});
        write_reg(REG_DRIFT, {16'd0, dr});
        write_reg(REG_DIFFUSION, {17'd0, df});
        write_reg(REG_STEPS, {32'd0, st});
        write_reg(REG_PATHS, {24'd0, np});
        write_reg(REG_SCALE, sc);
        write_reg(REG_PUT, {47'd0, put});
        settings_used++;
    endtask

    task automatic send_sample(input logic [15:0] raw);
        int gap;
        @(negedge clk);
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid = 0;
            repeat (gap - 1) @(negedge clk);
            @(negedge clk);
        end
        s_tvalid = 1;
        s_tdata  = raw;
        do @(posedge clk); while (!(s_tvalid && s_tready));
        samples_sent++;
    endtask

    // Drop valid, drain all predicted prices, then let an in-flight path end finish.
    task automatic drain;
        @(negedge clk);
        s_tvalid = 0;
        while (pending != 0) @(posedge clk);
        repeat (100) @(negedge clk);
    endtask

    initial begin
        logic [31:0] sp, k, dr;
        logic [30:0] df;
        logic [15:0] st;
        logic [23:0] np;
        logic [47:0] sc;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // reset defaults: 252-step path, one path, zero scale
        repeat (252) send_sample(16'h0000);
        drain();

        program_pricer(32'd100 << 16, 32'd100 << 16, 32'd0, 31'h0033_3333,
                       16'd1, 24'd1, 48'h8000_0000_0000, 1'b0);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'h0000);
        send_sample(16'h0001);
        send_sample(16'hFFFF);
        drain();
        program_pricer(32'd100 << 16, 32'd100 << 16, 32'd0, 31'h0033_3333,
                       16'd1, 24'd1, 48'hFFFF_FFFF_FFFF, 1'b1);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        drain();
        // log offset saturation both ways, maximum spot, zero counts act as one
        program_pricer(32'hFFFF_FFFF, 32'd0, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
                       16'd0, 24'd0, 48'hFFFF_FFFF_FFFF, 1'b0);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        drain();
        program_pricer(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF,
                       16'd0, 24'd0, 48'd0, 1'b1);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        drain();
        // multi-step, multi-path with a tiny end price
        program_pricer(32'd1, 32'd1 << 16, 32'hF000_0000, 31'h0100_0000,
                       16'd3, 24'd2, 48'h4000_0000_0000, 1'b1);
        repeat (6) send_sample(16'($urandom));
        drain();

        for (int ph = 0; ph < 12; ph++) begin
            no_idle = ($urandom_range(0, 3) == 0);
            sp = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(20, 400) << 16;
            k  = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(20, 400) << 16;
            dr = $urandom_range(0, 4) == 0 ? $urandom
                 : 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
            df = $urandom_range(0, 4) == 0 ? 31'($urandom) : 31'($urandom_range(0, 1 << 23));
            st = 16'($urandom_range(0, 6));
            np = 24'($urandom_range(0, 6));
            sc = $urandom_range(0, 2) == 0 ? 48'({$urandom, $urandom}) : 48'h1000_0000_0000;
            if (ph == 0) begin
                st = 1;
                np = 1;
                no_idle = 0;
            end
            program_pricer(sp, k, dr, df, st, np, sc, 1'($urandom_range(0, 1)));
            if (ph == 0)
                hold_req = 1;
            repeat (80) send_sample(16'($urandom));
            drain();
        end
        no_idle = 0;

        $display("%0d samples sent, %0d prices checked over %0d register settings",
                 samples_sent, results, settings_used);
        $display("covered call and put payoffs, log and price saturation, zero counts");
        if (errors == 0)
            $display("monte_carlo_option_pricer_test passed");
        else
            $display("monte_carlo_option_pricer_test failed");
        $finish;
    end
endmodule
